// ===== sv/lfu_pkg.sv =====
`default_nettype none
package lfu_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int CAP_MAX      = 256;

	localparam logic [4:0]  ACAP_RESET = 5'd16;
	localparam logic        FUNC_GET   = 1'b0;
	localparam logic        FUNC_PUT   = 1'b1;
	localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
	localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;
	localparam logic [31:0] COUNT_NEW  = 32'd1;

endpackage
`default_nettype wire

// ===== sv/lfu_cache_with_lru_tiebreak_top.sv =====
// Key-value cache with least-frequently-used replacement and least-recently-used
// tie-break. Entries live in a single memory with one read and one write port.
// A transaction is taken in the idle state and is followed by a pass over all
// entries to find the key, the first free slot and the victim. A second
// read-modify-write pass then updates counts and recency ranks, and the done
// state loads the output register. The block returns to idle in the same
// cycle as that load, so the next transaction is accepted only after the
// previous one has finished both passes. A stalled output can add more:
// the following transaction then waits before loading its result until the
// previous one has been taken. Valid bits are flip-flops cleared by reset, so
// no clearing pass is needed.
`default_nettype none
module lfu_cache_with_lru_tiebreak_top #(
	parameter int CAPACITY = lfu_pkg::CAPACITY_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic        [4:0]  cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               func,
	input  wire logic signed [31:0] key,
	input  wire logic signed [31:0] value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    hit,
	output logic signed      [31:0] read_value,
	output logic                    evicted,
	output logic signed      [31:0] evicted_key
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic [31:0]   key;
		logic [31:0]   val;
		logic [31:0]   cnt;
		logic [IW-1:0] age;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_UPD  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t        state_q;
	logic [4:0]    acap_q;
	logic [CW-1:0] occ_q;
	logic [CW-1:0] cnt_q;
	logic [CAPACITY-1:0] valid_q;

	logic        func_q;
	logic [31:0] key_q;
	logic [31:0] value_q;

	logic [IW-1:0] idx_s1;
	logic          vld_s1;

	logic          match_q;
	logic [IW-1:0] match_idx_q;
	logic [IW-1:0] match_age_q;
	logic [31:0]   match_val_q;
	logic          vic_found_q;
	logic [IW-1:0] vic_idx_q;
	logic [31:0]   vic_cnt_q;
	logic [IW-1:0] vic_age_q;
	logic [31:0]   vic_key_q;
	logic          free_found_q;
	logic [IW-1:0] free_idx_q;

	logic        res_hit_q;
	logic [31:0] res_rd_q;
	logic        res_ev_q;
	logic [31:0] res_evk_q;

	logic        out_valid_q;
	logic        out_hit_q;
	logic [31:0] out_rd_q;
	logic        out_ev_q;
	logic [31:0] out_evk_q;

	entry_t        rd_ent;
	entry_t        wr_ent;
	logic          mem_re;
	logic          mem_we;
	logic          accept;
	logic          pass_rd;
	logic          pass_end;
	logic [8:0]    eff_cap;
	logic          evict;
	logic          ins_ok;
	logic [IW-1:0] ins_idx;
	logic          ent_valid;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign pass_rd  = (cnt_q < CW'(CAPACITY));
	assign pass_end = !pass_rd;
	assign mem_re   = ((state_q == ST_SCAN) || (state_q == ST_UPD)) && pass_rd;
	assign ent_valid = valid_q[idx_s1];

	always_comb begin
		if (acap_q == 5'd0) begin
			eff_cap = 9'd1;
		end else if ({4'b0, acap_q} > 9'(CAPACITY)) begin
			eff_cap = 9'(CAPACITY);
		end else begin
			eff_cap = {4'b0, acap_q};
		end
	end

	assign evict  = (func_q == lfu_pkg::FUNC_PUT) && !match_q && vic_found_q &&
		(9'(occ_q) >= eff_cap);
	assign ins_ok = (func_q == lfu_pkg::FUNC_PUT) && !match_q && (evict || free_found_q);
	assign ins_idx = (evict && (!free_found_q || (vic_idx_q < free_idx_q))) ?
		vic_idx_q : free_idx_q;

	always_comb begin
		wr_ent = rd_ent;
		if (match_q) begin
			if (idx_s1 == match_idx_q) begin
				wr_ent.age = '0;
				wr_ent.cnt = (rd_ent.cnt == lfu_pkg::COUNT_MAX) ? rd_ent.cnt :
					rd_ent.cnt + 32'd1;
				if (func_q == lfu_pkg::FUNC_PUT) begin
					wr_ent.val = value_q;
				end
			end else if (ent_valid && (rd_ent.age < match_age_q)) begin
				wr_ent.age = rd_ent.age + IW'(1);
			end
		end else if (ins_ok && (idx_s1 == ins_idx)) begin
			wr_ent.key = key_q;
			wr_ent.val = value_q;
			wr_ent.cnt = lfu_pkg::COUNT_NEW;
			wr_ent.age = '0;
		end else if (ent_valid && !(evict && (idx_s1 == vic_idx_q))) begin
			if (!(evict && (rd_ent.age > vic_age_q))) begin
				wr_ent.age = rd_ent.age + IW'(1);
			end
		end
	end

	assign mem_we = (state_q == ST_UPD) && vld_s1 &&
		(match_q || (func_q == lfu_pkg::FUNC_PUT));

	lfu_mem #(
		.DEPTH (CAPACITY),
		.AW    (IW),
		.DW    ($bits(entry_t))
	) u_mem (
		.clk     (clk),
		.rd_en   (mem_re),
		.rd_addr (cnt_q[IW-1:0]),
		.rd_data (rd_ent),
		.wr_en   (mem_we),
		.wr_addr (idx_s1),
		.wr_data (wr_ent)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acap_q <= lfu_pkg::ACAP_RESET;
		end else if (cfg_wr_en) begin
			acap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			occ_q       <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= mem_re;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (pass_end) begin
						cnt_q   <= '0;
						state_q <= ST_UPD;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_UPD: begin
					if (pass_end) begin
						cnt_q   <= '0;
						state_q <= ST_DONE;
						if (evict) begin
							valid_q[vic_idx_q] <= 1'b0;
						end
						if (ins_ok) begin
							valid_q[ins_idx] <= 1'b1;
							if (!evict) begin
								occ_q <= occ_q + CW'(1);
							end
						end
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			idx_s1 <= cnt_q[IW-1:0];
		end
		if (accept) begin
			func_q       <= func;
			key_q        <= key;
			value_q      <= value;
			match_q      <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if ((state_q == ST_SCAN) && vld_s1) begin
			if (ent_valid && (rd_ent.key == key_q) && !match_q) begin
				match_q     <= 1'b1;
				match_idx_q <= idx_s1;
				match_age_q <= rd_ent.age;
				match_val_q <= rd_ent.val;
			end
			if (!ent_valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
			if (ent_valid && (!vic_found_q || (rd_ent.cnt < vic_cnt_q) ||
				((rd_ent.cnt == vic_cnt_q) && (rd_ent.age > vic_age_q)))) begin
				vic_found_q <= 1'b1;
				vic_idx_q   <= idx_s1;
				vic_cnt_q   <= rd_ent.cnt;
				vic_age_q   <= rd_ent.age;
				vic_key_q   <= rd_ent.key;
			end
		end
		if ((state_q == ST_UPD) && pass_end) begin
			res_hit_q <= match_q;
			if (func_q == lfu_pkg::FUNC_PUT) begin
				res_rd_q <= '0;
			end else if (match_q) begin
				res_rd_q <= match_val_q;
			end else begin
				res_rd_q <= lfu_pkg::MISS_VALUE;
			end
			res_ev_q  <= evict;
			res_evk_q <= evict ? vic_key_q : '0;
		end
		if ((state_q == ST_DONE) && (!out_valid_q || !out_stall)) begin
			out_hit_q <= res_hit_q;
			out_rd_q  <= res_rd_q;
			out_ev_q  <= res_ev_q;
			out_evk_q <= res_evk_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = out_hit_q;
	assign read_value  = out_rd_q;
	assign evicted     = out_ev_q;
	assign evicted_key = out_evk_q;

	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(occ_q))
		else $error("occupancy disagrees with valid bits");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= CAPACITY)
		else $error("occupancy above capacity");

	a_write_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_UPD))
		else $error("memory written outside update pass");

	a_evict_keeps_occ: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_UPD) && pass_end && evict) |=> $stable(occ_q))
		else $error("eviction changed occupancy");

endmodule
`default_nettype wire

// ===== sv/lfu_mem.sv =====
`default_nettype none
module lfu_mem #(
	parameter int DEPTH = lfu_pkg::CAPACITY_DEF,
	parameter int AW    = 4,
	parameter int DW    = 100
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire
